FILE: hw/rtl/prr_pkg.sv
// Shared types and constants for the polyphase rational resampler.
// No dependencies; used by prr_mac and polyphase_rational_resampler.
`default_nettype none

package prr_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_IDX_W = 6;
  localparam int unsigned NUM_TAPS_W = 7;
  localparam int unsigned FACTOR_W   = 5;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned OUT_SHIFT  = 15;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM    = 2'd2;

  localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RST = 7'd64;
  localparam logic [FACTOR_W-1:0]   FACTOR_RST   = 5'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Control from the sequencer to the MAC unit
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic en;     // operands valid this cycle
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module prr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/prr_mac.sv
// Shared multiply-accumulate unit: registered 16x16 product, wrapping 32-bit sum.
// Depends on prr_pkg.
`default_nettype none

module prr_mac (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire prr_pkg::mac_ctrl_t         ctrl_i,
  input  wire prr_pkg::sample_t           coef_i,
  input  wire prr_pkg::sample_t           data_i,
  output logic [prr_pkg::ACC_W-1:0]       acc_o,
  output logic                            busy_o
);

  logic signed [prr_pkg::ACC_W-1:0] prod_d;
  logic signed [prr_pkg::ACC_W-1:0] prod_q;
  logic                             pv_q;
  logic        [prr_pkg::ACC_W-1:0] acc_q;

  assign prod_d = prr_pkg::ACC_W'(coef_i) * prr_pkg::ACC_W'(data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + prod_q;  // wraps modulo 2^32
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = pv_q;

endmodule

`default_nettype wire

FILE: hw/rtl/polyphase_rational_resampler.sv
// Polyphase L/M FIR resampler: top level with sequencer, delay and coefficient RAMs.
// Depends on prr_pkg, prr_ram and prr_mac.
`default_nettype none

// Polyphase rational resampler. Each input transfer either loads one Q15
// coefficient (no output) or delivers one sample. A sample is shifted into
// the delay line, then one output is produced per polyphase branch j =
// phase, phase+M, ... below L; each output is the sum of coef[j+kL]*delay[k]
// over the taps in use, kept in a wrapping 32-bit accumulator, and reported
// as bits 30..15. The phase left over carries to the next sample. All
// arithmetic goes through one multiply-accumulate unit fed from two
// single-read-port RAMs. A sample is taken in and the delay line shifted one
// entry per cycle through the RAM port; then each output takes a branch
// start, one tap per cycle, an end check, a wait for the MAC pipeline to
// drain and the emit step; a final step closes the run. A stalled result
// holds the emit step of the next output. in_stall_o is high while a sample
// is being worked on. After reset the delay RAM is zeroed entry by entry; no
// input transfer is taken in that time, configuration writes are. The output
// register decouples the result side: the next branch is computed while a
// result waits.
module polyphase_rational_resampler #(
  parameter int unsigned MAX_TAPS   = 64,
  parameter int unsigned MAX_FACTOR = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [prr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [prr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                req_type_i,
  input  wire prr_pkg::sample_t                    sample_in_i,
  input  wire logic [prr_pkg::COEF_IDX_W-1:0]      coef_index_i,
  input  wire prr_pkg::sample_t                    coef_value_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output prr_pkg::sample_t                         out_sample_o,
  output logic                                     last_of_run_o
);

  // Widths derived from the parameters
  localparam int unsigned AW  = $clog2(MAX_TAPS);          // RAM address
  localparam int unsigned TW  = $clog2(MAX_TAPS + 1);      // tap count / counter
  localparam int unsigned NW  = (TW > prr_pkg::NUM_TAPS_W) ? TW : prr_pkg::NUM_TAPS_W;
  localparam int unsigned FW  = $clog2(MAX_FACTOR + 1);    // clamped L, M
  localparam int unsigned XW  = (FW > prr_pkg::FACTOR_W) ? FW : prr_pkg::FACTOR_W;
  localparam int unsigned JW  = $clog2(2 * MAX_FACTOR);    // running branch index
  localparam int unsigned PW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int unsigned CIW = $clog2(MAX_TAPS + MAX_FACTOR); // coefficient index
  localparam int unsigned IW  = (AW > prr_pkg::COEF_IDX_W) ? AW : prr_pkg::COEF_IDX_W;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;  // zero delay RAM after reset
  localparam logic [2:0] S_IDLE  = 3'd1;  // wait for an input transfer
  localparam logic [2:0] S_SHIFT = 3'd2;  // move delay line up one entry per cycle
  localparam logic [2:0] S_LOAD0 = 3'd3;  // last shift write, then new sample at 0
  localparam logic [2:0] S_PHASE = 3'd4;  // start a branch or close the run
  localparam logic [2:0] S_ISSUE = 3'd5;  // one tap read per cycle into the MAC
  localparam logic [2:0] S_DRAIN = 3'd6;  // wait for the MAC pipeline
  localparam logic [2:0] S_EMIT  = 3'd7;  // hand the sum to the output register

  function automatic logic [FW-1:0] clamp_factor(input logic [prr_pkg::FACTOR_W-1:0] f);
    logic [XW-1:0] fx;
    fx = XW'(f);
    if (fx == '0) begin
      return FW'(1);
    end else if (fx > XW'(MAX_FACTOR)) begin
      return FW'(MAX_FACTOR);
    end else begin
      return FW'(fx);
    end
  endfunction

  // Configuration registers
  logic [prr_pkg::NUM_TAPS_W-1:0] num_taps_q;
  logic [prr_pkg::FACTOR_W-1:0]   interp_q;
  logic [prr_pkg::FACTOR_W-1:0]   decim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_taps_q <= prr_pkg::NUM_TAPS_RST;
      interp_q   <= prr_pkg::FACTOR_RST;
      decim_q    <= prr_pkg::FACTOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prr_pkg::CFG_NUM_TAPS: num_taps_q <= cfg_data_i[prr_pkg::NUM_TAPS_W-1:0];
        prr_pkg::CFG_INTERP:   interp_q   <= cfg_data_i[prr_pkg::FACTOR_W-1:0];
        prr_pkg::CFG_DECIM:    decim_q    <= cfg_data_i[prr_pkg::FACTOR_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Effective settings, clamped to what the hardware holds
  logic [NW-1:0] nt_ext;
  logic [TW-1:0] taps_clamp;

  assign nt_ext     = NW'(num_taps_q);
  assign taps_clamp = (nt_ext > NW'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(nt_ext);

  // Sequencer state
  logic [2:0]             state_q, state_d;
  logic [TW-1:0]          cnt_q, cnt_d;
  prr_pkg::sample_t       sample_q, sample_d;
  logic [TW-1:0]          taps_q, taps_d;
  logic [FW-1:0]          l_q, l_d;
  logic [FW-1:0]          m_q, m_d;
  logic [PW-1:0]          phase_q, phase_d;
  logic [JW-1:0]          j_q, j_d;
  logic [CIW-1:0]         ci_q, ci_d;
  logic [TW-1:0]          k_q, k_d;
  logic                   shift_pend_q, shift_pend_d;
  logic [AW-1:0]          shift_waddr_q, shift_waddr_d;
  logic                   rd_pend_q, rd_pend_d;
  logic                   out_valid_q, out_valid_d;
  prr_pkg::sample_t       out_sample_q;
  logic                   out_last_q;

  // RAM ports
  logic                   dly_we;
  logic [AW-1:0]          dly_waddr;
  prr_pkg::sample_t       dly_wdata;
  logic [AW-1:0]          dly_raddr;
  prr_pkg::sample_t       dly_rdata;
  logic                   coef_we;
  logic [AW-1:0]          coef_waddr;
  logic [AW-1:0]          coef_raddr;
  prr_pkg::sample_t       coef_rdata;

  // MAC
  prr_pkg::mac_ctrl_t          mac_ctrl;
  logic [prr_pkg::ACC_W-1:0]   mac_acc;
  logic                        mac_busy;

  logic                   in_accept;
  logic [IW-1:0]          coef_idx_ext;
  logic                   coef_in_range;
  logic [JW:0]            j_sum;
  logic                   out_load;
  logic                   out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Coefficient load goes straight to the RAM; slots past the table are dropped
  assign coef_idx_ext  = IW'(coef_index_i);
  assign coef_in_range = ((IW + 1)'(coef_idx_ext) < (IW + 1)'(MAX_TAPS));
  assign coef_we       = in_accept && req_type_i && coef_in_range;
  assign coef_waddr    = coef_idx_ext[AW-1:0];
  assign coef_raddr    = ci_q[AW-1:0];

  // Next branch index (which also gives the end-of-run flag) and output-register free flag
  assign j_sum    = (JW + 1)'(j_q) + (JW + 1)'(m_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    sample_d      = sample_q;
    taps_d        = taps_q;
    l_d           = l_q;
    m_d           = m_q;
    phase_d       = phase_q;
    j_d           = j_q;
    ci_d          = ci_q;
    k_d           = k_q;
    shift_pend_d  = 1'b0;
    shift_waddr_d = shift_waddr_q;
    rd_pend_d     = 1'b0;
    out_load      = 1'b0;
    dly_we        = 1'b0;
    dly_waddr     = shift_waddr_q;
    dly_wdata     = dly_rdata;
    dly_raddr     = k_q[AW-1:0];
    mac_ctrl      = '0;
    mac_ctrl.en   = rd_pend_q;

    case (state_q)
      S_CLEAR: begin
        dly_we    = 1'b1;
        dly_waddr = cnt_q[AW-1:0];
        dly_wdata = '0;
        if (cnt_q == TW'(MAX_TAPS - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + TW'(1);
        end
      end

      S_IDLE: begin
        if (in_accept && !req_type_i) begin
          sample_d = sample_in_i;
          taps_d   = taps_clamp;
          l_d      = clamp_factor(interp_q);
          m_d      = clamp_factor(decim_q);
          if (taps_clamp >= TW'(2)) begin
            cnt_d   = taps_clamp - TW'(2);
            state_d = S_SHIFT;
          end else begin
            state_d = S_LOAD0;
          end
        end
      end

      S_SHIFT: begin
        // read entry cnt now, write it to cnt+1 next cycle
        dly_raddr     = cnt_q[AW-1:0];
        shift_pend_d  = 1'b1;
        shift_waddr_d = AW'(cnt_q + TW'(1));
        dly_we        = shift_pend_q;
        if (cnt_q == '0) begin
          state_d = S_LOAD0;
        end else begin
          cnt_d = cnt_q - TW'(1);
        end
      end

      S_LOAD0: begin
        dly_we = 1'b1;
        if (!shift_pend_q) begin
          dly_waddr = '0;
          dly_wdata = sample_q;
          j_d       = JW'(phase_q);
          state_d   = S_PHASE;
        end
      end

      S_PHASE: begin
        if (j_q < JW'(l_q)) begin
          ci_d           = CIW'(j_q);
          k_d            = '0;
          mac_ctrl.clear = 1'b1;
          state_d        = S_ISSUE;
        end else begin
          // run over: carry what is left of the phase
          phase_d = PW'(j_q - JW'(l_q));
          state_d = S_IDLE;
        end
      end

      S_ISSUE: begin
        if (ci_q < CIW'(taps_q)) begin
          rd_pend_d = 1'b1;
          ci_d      = ci_q + CIW'(l_q);
          k_d       = k_q + TW'(1);
        end else begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (!rd_pend_q && !mac_busy) begin
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          j_d      = JW'(j_sum);
          state_d  = S_PHASE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      phase_q      <= '0;
      shift_pend_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      phase_q      <= phase_d;
      shift_pend_q <= shift_pend_d;
      rd_pend_q    <= rd_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sample_q      <= sample_d;
    taps_q        <= taps_d;
    l_q           <= l_d;
    m_q           <= m_d;
    j_q           <= j_d;
    ci_q          <= ci_d;
    k_q           <= k_d;
    shift_waddr_q <= shift_waddr_d;
    if (out_load) begin
      out_sample_q <= mac_acc[prr_pkg::OUT_SHIFT + prr_pkg::SAMPLE_W - 1:prr_pkg::OUT_SHIFT];
      out_last_q   <= (j_sum >= (JW + 1)'(l_q));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign last_of_run_o = out_last_q;

  prr_ram #(
    .WIDTH (prr_pkg::SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  prr_ram #(
    .WIDTH (prr_pkg::SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_value_i),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  prr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rdata),
    .data_i (dly_rdata),
    .acc_o  (mac_acc),
    .busy_o (mac_busy)
  );

  // A new result only appears right after the emit step
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
    else $error("output valid rose outside emit step");

  // Delay-line shift never reads the entry it is writing
  a_shift_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && shift_pend_q) |-> (shift_waddr_q != cnt_q[AW-1:0]))
    else $error("delay RAM read/write collision during shift");

  // Accumulator is only cleared with the MAC pipeline empty
  a_clear_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.clear |-> (!rd_pend_q && !mac_busy))
    else $error("MAC cleared with products in flight");

  // Delay index stays inside the taps in use while issuing
  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE && ci_q < CIW'(taps_q)) |-> (k_q < taps_q))
    else $error("delay index beyond tap count");

endmodule

`default_nettype wire
